FILE: design/led_bw_pkg.sv
// ----------------------------------------------------------------------------
// led_bw_pkg
// Shared types and constants for the LED brightness waveform generator.
// ----------------------------------------------------------------------------
package led_bw_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } lbw_state_t;

  // Effect modes
  typedef enum logic [1:0] {
    MODE_RAMP  = 2'd0,
    MODE_GLOW  = 2'd1,
    MODE_MULTI = 2'd2,
    MODE_NONE  = 2'd3
  } lbw_mode_t;

  // Config register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_PERIOD = 3'd1;
  localparam logic [2:0] REG_DELAY  = 3'd2;
  localparam logic [2:0] REG_HOLD   = 3'd3;
  localparam logic [2:0] REG_COLOR1 = 3'd4;
  localparam logic [2:0] REG_COLOR2 = 3'd5;

  // Input opcodes
  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  localparam logic [15:0] PERIOD_MIN   = 16'd2;
  localparam logic [15:0] PERIOD_RESET = 16'd100;
  localparam logic [8:0]  TICKS_MAX    = 9'd300;

  // Bits of the color channel; one multiply and one divide step per bit
  localparam int unsigned CH_BITS = 8;

endpackage

FILE: design/led_brightness_waveform_top.sv
// ----------------------------------------------------------------------------
// led_brightness_waveform_top
// Tick counter plus ramp / glow / two-color glow brightness per request.
// Sequence: input accept, then setup, bit-serial multiply, bit-serial divide
//   and output load, which waits until the output register is free.
// Flow: one request at a time; in_tready is high only when idle,
//   while the output register may still hold an untaken result.
// Reset: rst_n synchronous active low; counter 0, period 100, other config 0, out_tvalid 0; datapath not reset.
// ----------------------------------------------------------------------------
module led_brightness_waveform_top
  import led_bw_pkg::*;
#(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] load_time
  input  logic        in_tuser,   // [0] opcode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue,
                                  // [39:24] time_now
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // Counter compare width: holds the counter or load value plus one carry bit
  localparam int unsigned CW = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;
  // Setup arithmetic width: room for 4 * t and 4 * T
  localparam int unsigned XW = CW + 2;
  localparam int unsigned PW = 3 * CH_BITS;  // product width

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  lbw_mode_t   mode_r;
  logic [15:0] period_r;
  logic [8:0]  delay_r;
  logic [8:0]  hold_r;
  logic [23:0] color1_r;
  logic [23:0] color2_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RAMP;
      period_r <= PERIOD_RESET;
      delay_r  <= '0;
      hold_r   <= '0;
      color1_r <= '0;
      color2_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   mode_r <= lbw_mode_t'(cfg_data[1:0]);
        REG_PERIOD: if (cfg_data[15:0] >= PERIOD_MIN) period_r <= cfg_data[15:0];
        REG_DELAY:  if (cfg_data[8:0] <= TICKS_MAX) delay_r <= cfg_data[8:0];
        REG_HOLD:   if (cfg_data[8:0] <= TICKS_MAX) hold_r <= cfg_data[8:0];
        REG_COLOR1: color1_r <= cfg_data;
        REG_COLOR2: color2_r <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  lbw_state_t            state_r, state_nxt;
  logic [2:0]            cnt_r, cnt_nxt;          // bit step within a phase
  logic [TIME_BITS-1:0]  tick_r, tick_nxt;        // tick counter
  logic [15:0]           num_r, num_nxt;          // common numerator
  logic [15:0]           den_r, den_nxt;          // common divisor
  logic                  zero_r, zero_nxt;        // force black
  logic                  full_r, full_nxt;        // force unscaled color
  // Per-lane color shift registers (rotate, so the color is back after the multiply phase)
  logic [2:0][7:0]       clr_r, clr_nxt;
  // Per-lane working register: product, then {remainder, quotient}
  logic [2:0][PW-1:0]    acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [39:0]           out_data_r, out_data_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    logic [CW-1:0]   t_adv;
    logic [CW-1:0]   t_cnt;
    logic [CW-1:0]   per_c;
    logic [CW-1:0]   ld_c;
    logic [XW-1:0]   t_x, per_x, p_x, d_x, tw, q4, per2, per3, per4;
    logic [XW-1:0]   num_x, den_x;
    logic            use_second;
    logic            ramp_ok;
    logic [23:0]     src;
    logic [16:0]     trial;
    logic [16:0]     diffw;
    logic            qbit;
    logic [CW-1:0]   t_out;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    tick_nxt      = tick_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    zero_nxt      = zero_r;
    full_nxt      = full_r;
    clr_nxt       = clr_r;
    acc_nxt       = acc_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    // counter update
    per_c = CW'(period_r);
    t_cnt = CW'(tick_r);
    t_adv = t_cnt + CW'(1);
    ld_c  = CW'(in_tdata);

    // setup terms
    t_x   = XW'(tick_r);
    per_x = XW'(period_r);
    d_x   = XW'(delay_r);
    p_x   = XW'(delay_r) + XW'(hold_r);
    tw    = t_x << 1;
    q4    = t_x << 2;
    per2  = per_x << 1;
    per3  = per_x + per2;
    per4  = per_x << 2;
    num_x = '0;
    den_x = per_x;
    use_second = 1'b0;
    ramp_ok    = 1'b0;
    src        = color1_r;
    trial      = '0;
    diffw      = '0;
    qbit       = 1'b0;
    t_out      = CW'(tick_r);

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == OP_LOAD) begin
            tick_nxt = (ld_c >= per_c) ? '0 : ld_c[TIME_BITS-1:0];
          end else begin
            tick_nxt = (t_adv > per_c) ? '0 : t_adv[TIME_BITS-1:0];
          end
          state_nxt = ST_SETUP;
        end
      end

      ST_SETUP: begin
        zero_nxt = 1'b0;
        full_nxt = 1'b0;
        case (mode_r)
          MODE_RAMP: begin
            ramp_ok  = (p_x < per_x) && (t_x >= p_x);
            num_x    = t_x - p_x;
            den_x    = per_x - p_x;
            full_nxt = (t_x + p_x) > per_x;
            zero_nxt = !ramp_ok || (t_x < d_x);
          end
          MODE_GLOW: begin
            num_x = (tw >= per_x) ? (tw - per_x) : (per_x - tw);
          end
          MODE_MULTI: begin
            if (q4 < per_x) begin
              num_x = q4;
            end else if (q4 < per2) begin
              num_x = per2 - q4;
            end else if (q4 < per3) begin
              num_x      = q4 - per2;
              use_second = 1'b1;
            end else begin
              num_x      = (q4 >= per4) ? (q4 - per4) : (per4 - q4);
              use_second = 1'b1;
            end
          end
          default: begin
            zero_nxt = 1'b1;  // unused mode gives black
          end
        endcase
        src     = use_second ? color2_r : color1_r;
        num_nxt = num_x[15:0];
        den_nxt = den_x[15:0];
        for (int k = 0; k < 3; k++) begin
          clr_nxt[k] = src[16-8*k +: 8];  // lane 0 red, 1 green, 2 blue
          acc_nxt[k] = '0;
        end
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end

      ST_MUL: begin
        // product = c * num, color MSB first
        for (int k = 0; k < 3; k++) begin
          acc_nxt[k] = (acc_r[k] << 1) + (clr_r[k][7] ? PW'(num_r) : '0);
          clr_nxt[k] = {clr_r[k][6:0], clr_r[k][7]};
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(CH_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        // restoring division, quotient < 256 since num <= den
        for (int k = 0; k < 3; k++) begin
          diffw = {acc_r[k][PW-1:CH_BITS], acc_r[k][CH_BITS-1]};
          trial = diffw - {1'b0, den_r};
          qbit  = (diffw >= {1'b0, den_r});
          acc_nxt[k] = {(qbit ? trial[15:0] : diffw[15:0]),
                        acc_r[k][CH_BITS-2:0], qbit};
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(CH_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          for (int k = 0; k < 3; k++) begin
            out_data_nxt[8*k +: 8] = full_r ? clr_r[k] :
                                     zero_r ? 8'd0 : acc_r[k][CH_BITS-1:0];
          end
          out_data_nxt[39:24] = t_out[15:0];
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    zero_r     <= zero_nxt;
    full_r     <= full_nxt;
    clr_r      <= clr_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
